[src/free_list_heap_allocator_unit_assert.svh]
// Assertion macros used by the allocator controller.
// The enclosing module must provide i_clk and i_rst_n.
`ifndef FREE_LIST_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FREE_LIST_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FLHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define FLHA_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FLHA_ASSERT(lbl, prop, msg)
`define FLHA_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

[src/flha_pkg.sv]
`timescale 1ns / 1ps
package flha_pkg;

    localparam int ARENA_BYTES  = 4096;
    localparam int HEADER_BYTES = 24;
    localparam int WORD_BYTES   = 8;
    localparam int NWORDS       = ARENA_BYTES / WORD_BYTES;
    localparam int IDX_W        = $clog2(NWORDS);
    localparam int OFF_W        = $clog2(ARENA_BYTES) + 2;
    localparam int DATA_W       = 64;
    localparam int OVERHEAD     = 16;
    localparam int MIN_REST     = 24;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [OFF_W-1:0] t_off;

    typedef enum logic [2:0] {
        ST_OK, ST_ZERO, ST_NOFIT, ST_NOBLK, ST_FREED, ST_GUARD
    } t_status;

    // datapath micro-operations
    typedef enum logic [4:0] {
        C_NOP, C_INIT0, C_INIT1, C_LOAD,
        C_P_RD, C_P_SZ, C_P_NX, C_P_END, C_P_BN,
        C_A_SIZE, C_A_GRD, C_A_RSZ, C_A_RNX, C_A_LINK,
        C_F_RD, C_F_SZ, C_F_FN, C_F_GSZ, C_F_FSRD, C_F_FS, C_F_FNX,
        C_F_PRD, C_F_PW, C_F_PN, C_F_W0, C_F_W1, C_F_W2,
        C_RES
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status st;
    } t_cmd;

    typedef struct packed {
        logic req_zero;
        logic addr_lt8;
        logic is_free;
        logic cur_end;
        logic pick_vld;
        logic no_fit;
        logic first_hit;
        logic split;
        logic cur_lt_tgt;
        logic cur_eq_tgt;
        logic cur_eq_fcur;
        logic rd_sz_zero;
        logic sz_zero;
        logic sz_lt8;
        logic guard_ok;
        logic after_free;
        logic before_free;
        logic out_busy;
    } t_stat;

endpackage

[src/flha_ram.sv]
`timescale 1ns / 1ps
module flha_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/flha_dp.sv]
`timescale 1ns / 1ps
module flha_dp
    import flha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_op,
    input  logic [12:0] i_req_size,
    input  logic [11:0] i_free_addr,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [11:0] o_alloc_addr,
    output logic [2:0]  o_status
);

    localparam t_off ARENA_END = OFF_W'(ARENA_BYTES);
    localparam t_off WORD      = OFF_W'(WORD_BYTES);

    logic [1:0]  r_policy;
    t_off        r_head;
    logic        r_out_vld;
    logic [11:0] r_out_addr;
    t_status     r_out_st;

    logic        r_op;
    logic        r_req_zero;
    logic [11:0] r_faddr;
    t_off        r_need, r_cur, r_prev, r_pick, r_best, r_ppred, r_bnext;
    t_off        r_fcur, r_prevf, r_sz, r_fsize, r_fnext;
    logic        r_prev_vld, r_pick_vld, r_ppred_vld, r_have_prev, r_bf;
    logic        r_rd_oor;

    logic [DATA_W-1:0] w_ram_q, w_rdata, w_wdata;
    t_off        w_rsz, w_raddr, w_waddr, w_need_in, w_tgt, w_blk_sz, w_link_tgt;
    logic        w_we, w_take, w_split, w_after_free;
    logic [11:0] w_res_addr;

    assign w_rdata    = r_rd_oor ? '0 : w_ram_q;
    assign w_rsz      = w_rdata[OFF_W-1:0];
    assign w_need_in  = (OFF_W'(i_req_size) + OFF_W'(OVERHEAD + WORD_BYTES - 1))
                        & ~OFF_W'(WORD_BYTES - 1);
    assign w_tgt      = OFF_W'(r_faddr) - WORD;
    assign w_split    = r_best >= (r_need + OFF_W'(MIN_REST));
    assign w_blk_sz   = w_split ? r_need : r_best;
    assign w_link_tgt = w_split ? (r_pick + r_need) : r_bnext;
    assign w_after_free = (r_fcur < ARENA_END) && ((r_cur + r_sz) == r_fcur);
    assign w_res_addr = OFF_W'(r_pick + WORD) >= ARENA_END ? 12'(r_pick + WORD)
                                                           : 12'(r_pick + WORD);

    // fit decision for the block just read
    always_comb begin
        case (r_policy)
            POL_BEST:  w_take = (w_rsz >= r_need) && (!r_pick_vld || (w_rsz < r_best));
            POL_WORST: w_take = !r_pick_vld || (w_rsz >= r_best);
            default:   w_take = (w_rsz >= r_need);
        endcase
    end

    // select arena read and write for each micro-operation
    always_comb begin
        w_raddr = r_cur;
        w_waddr = r_cur;
        w_wdata = '0;
        w_we    = 1'b0;
        case (i_cmd.op)
            C_INIT0: begin
                w_we    = 1'b1;
                w_waddr = OFF_W'(HEADER_BYTES);
                w_wdata = DATA_W'(ARENA_BYTES - HEADER_BYTES);
            end
            C_INIT1: begin
                w_we    = 1'b1;
                w_waddr = OFF_W'(HEADER_BYTES + WORD_BYTES);
                w_wdata = DATA_W'(ARENA_BYTES);
            end
            C_P_RD:   w_raddr = r_cur;
            C_P_SZ:   w_raddr = r_cur + WORD;
            C_P_END:  w_raddr = r_pick + WORD;
            C_A_SIZE: begin
                w_we    = 1'b1;
                w_waddr = r_pick;
                w_wdata = DATA_W'(w_blk_sz);
            end
            C_A_GRD: begin
                w_we    = 1'b1;
                w_waddr = r_pick + w_blk_sz - WORD;
                w_wdata = '1;
            end
            C_A_RSZ: begin
                w_we    = 1'b1;
                w_waddr = r_pick + r_need;
                w_wdata = DATA_W'(r_best - r_need);
            end
            C_A_RNX: begin
                w_we    = 1'b1;
                w_waddr = r_pick + r_need + WORD;
                w_wdata = DATA_W'(r_bnext);
            end
            C_A_LINK: begin
                w_we    = r_ppred_vld;
                w_waddr = r_ppred + WORD;
                w_wdata = DATA_W'(w_link_tgt);
            end
            C_F_RD:   w_raddr = r_cur;
            C_F_SZ:   w_raddr = r_fcur + WORD;
            C_F_GSZ:  w_raddr = r_cur + w_rsz - WORD;
            C_F_FSRD: w_raddr = r_fcur;
            C_F_FS:   w_raddr = r_fcur + WORD;
            C_F_PRD:  w_raddr = r_prevf;
            C_F_PW: begin
                w_we    = 1'b1;
                w_waddr = r_prevf;
                w_wdata = DATA_W'(w_rsz + r_sz + (w_after_free ? r_fsize : '0));
            end
            C_F_PN: begin
                w_we    = 1'b1;
                w_waddr = r_prevf + WORD;
                w_wdata = DATA_W'(r_fnext);
            end
            C_F_W0: begin
                w_we    = r_have_prev;
                w_waddr = r_prevf + WORD;
                w_wdata = DATA_W'(r_cur);
            end
            C_F_W1: begin
                w_we    = 1'b1;
                w_waddr = r_cur;
                w_wdata = DATA_W'(w_after_free ? (r_sz + r_fsize) : r_sz);
            end
            C_F_W2: begin
                w_we    = 1'b1;
                w_waddr = r_cur + WORD;
                w_wdata = DATA_W'(w_after_free ? r_fnext : r_fcur);
            end
            default: ;
        endcase
    end

    flha_ram #(
        .WIDTH(DATA_W),
        .DEPTH(NWORDS)
    ) u_arena (
        .i_clk   (i_clk),
        .i_we    (w_we && (w_waddr < ARENA_END)),
        .i_waddr (w_waddr[IDX_W+2:3]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[IDX_W+2:3]),
        .o_rdata (w_ram_q)
    );

    // control registers: policy, list head, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= POL_FIRST;
            r_head    <= OFF_W'(HEADER_BYTES);
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            if (i_cmd.op == C_RES) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.op == C_A_LINK && !r_ppred_vld) begin
                r_head <= w_link_tgt;
            end
            if (i_cmd.op == C_F_W2 && !r_have_prev) begin
                r_head <= r_cur;
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        r_rd_oor <= !(w_raddr < ARENA_END);
        case (i_cmd.op)
            C_LOAD: begin
                r_op        <= i_op;
                r_faddr     <= i_free_addr;
                r_req_zero  <= (i_req_size == '0);
                r_need      <= w_need_in;
                r_cur       <= (i_op == OP_FREE) ? OFF_W'(HEADER_BYTES) : r_head;
                r_fcur      <= r_head;
                r_prev_vld  <= 1'b0;
                r_pick_vld  <= 1'b0;
                r_have_prev <= 1'b0;
                r_bf        <= 1'b0;
            end
            C_P_SZ: begin
                r_sz <= w_rsz;
                if (w_take) begin
                    r_pick      <= r_cur;
                    r_best      <= w_rsz;
                    r_pick_vld  <= 1'b1;
                    r_ppred     <= r_prev;
                    r_ppred_vld <= r_prev_vld;
                end
            end
            C_P_NX: begin
                r_prev     <= r_cur;
                r_prev_vld <= 1'b1;
                r_cur      <= w_rsz;
            end
            C_P_BN: r_bnext <= w_rsz;
            C_F_SZ: begin
                r_sz <= w_rsz;
                if (r_cur == r_fcur) begin
                    r_prevf     <= r_fcur;
                    r_have_prev <= 1'b1;
                    r_bf        <= 1'b1;
                end else begin
                    r_bf <= 1'b0;
                    if (w_rdata != '0) begin
                        r_cur <= r_cur + w_rsz;
                    end
                end
            end
            C_F_FN: begin
                r_fcur <= w_rsz;
                if (r_sz != '0) begin
                    r_cur <= r_cur + r_sz;
                end
            end
            C_F_GSZ: r_sz    <= w_rsz;
            C_F_FS:  r_fsize <= w_rsz;
            C_F_FNX: r_fnext <= w_rsz;
            C_RES: begin
                r_out_addr <= (r_op == OP_ALLOC && i_cmd.st == ST_OK) ? w_res_addr : '0;
                r_out_st   <= i_cmd.st;
            end
            default: ;
        endcase
    end

    // status toward the controller
    always_comb begin
        o_stat.req_zero    = r_req_zero;
        o_stat.addr_lt8    = r_faddr < 12'(WORD_BYTES);
        o_stat.is_free     = (r_op == OP_FREE);
        o_stat.cur_end     = r_cur >= ARENA_END;
        o_stat.pick_vld    = r_pick_vld;
        o_stat.no_fit      = !r_pick_vld || (r_policy == POL_WORST && r_best < r_need);
        o_stat.first_hit   = (r_policy != POL_BEST) && (r_policy != POL_WORST)
                             && (w_rsz >= r_need);
        o_stat.split       = w_split;
        o_stat.cur_lt_tgt  = r_cur < w_tgt;
        o_stat.cur_eq_tgt  = r_cur == w_tgt;
        o_stat.cur_eq_fcur = r_cur == r_fcur;
        o_stat.rd_sz_zero  = (w_rdata == '0);
        o_stat.sz_zero     = (r_sz == '0);
        o_stat.sz_lt8      = w_rdata < DATA_W'(WORD_BYTES);
        o_stat.guard_ok    = &w_rdata;
        o_stat.after_free  = w_after_free;
        o_stat.before_free = r_bf;
        o_stat.out_busy    = r_out_vld && !i_m_tready;
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_alloc_addr = r_out_addr;
    assign o_status     = r_out_st;

endmodule

[src/flha_ctrl.sv]
`timescale 1ns / 1ps
`include "free_list_heap_allocator_unit_assert.svh"
module flha_ctrl
    import flha_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_IDLE, S_DISP,
        S_P_CHK, S_P_SZ, S_P_NX, S_P_END, S_P_BN,
        S_A_SIZE, S_A_GRD, S_A_RSZ, S_A_RNX, S_A_LINK,
        S_F_CHK, S_F_SZ, S_F_FN, S_F_END, S_F_GSZ, S_F_GRD, S_F_FS, S_F_FNX,
        S_F_UPD, S_F_PW, S_F_PN, S_F_W0, S_F_W1, S_F_W2,
        S_RES
    } t_state;

    t_state  r_state;
    t_status r_res_st;

    // sequence one transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT0;
            r_res_st <= ST_OK;
        end else begin
            case (r_state)
                S_INIT0: r_state <= S_INIT1;
                S_INIT1: r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_s_tvalid) r_state <= S_DISP;
                end
                S_DISP: begin
                    if (i_stat.is_free) begin
                        if (i_stat.addr_lt8) begin
                            r_state <= S_RES; r_res_st <= ST_NOBLK;
                        end else begin
                            r_state <= S_F_CHK;
                        end
                    end else if (i_stat.req_zero) begin
                        r_state <= S_RES; r_res_st <= ST_ZERO;
                    end else begin
                        r_state <= S_P_CHK;
                    end
                end
                S_P_CHK: begin
                    if (!i_stat.cur_end) begin
                        r_state <= S_P_SZ;
                    end else if (i_stat.no_fit) begin
                        r_state <= S_RES; r_res_st <= ST_NOFIT;
                    end else begin
                        r_state <= S_P_END;
                    end
                end
                S_P_SZ:   r_state <= i_stat.first_hit ? S_P_BN : S_P_NX;
                S_P_NX:   r_state <= S_P_CHK;
                S_P_END:  r_state <= S_P_BN;
                S_P_BN:   r_state <= S_A_SIZE;
                S_A_SIZE: r_state <= S_A_GRD;
                S_A_GRD:  r_state <= i_stat.split ? S_A_RSZ : S_A_LINK;
                S_A_RSZ:  r_state <= S_A_RNX;
                S_A_RNX:  r_state <= S_A_LINK;
                S_A_LINK: begin
                    r_state <= S_RES; r_res_st <= ST_OK;
                end
                S_F_CHK:  r_state <= i_stat.cur_lt_tgt ? S_F_SZ : S_F_END;
                S_F_SZ: begin
                    if (i_stat.cur_eq_fcur)     r_state <= S_F_FN;
                    else if (i_stat.rd_sz_zero) r_state <= S_F_END;
                    else                        r_state <= S_F_CHK;
                end
                S_F_FN:   r_state <= i_stat.sz_zero ? S_F_END : S_F_CHK;
                S_F_END: begin
                    if (!i_stat.cur_eq_tgt) begin
                        r_state <= S_RES; r_res_st <= ST_NOBLK;
                    end else if (i_stat.cur_eq_fcur) begin
                        r_state <= S_RES; r_res_st <= ST_FREED;
                    end else begin
                        r_state <= S_F_GSZ;
                    end
                end
                S_F_GSZ: begin
                    if (i_stat.sz_lt8) begin
                        r_state <= S_RES; r_res_st <= ST_GUARD;
                    end else begin
                        r_state <= S_F_GRD;
                    end
                end
                S_F_GRD: begin
                    if (!i_stat.guard_ok) begin
                        r_state <= S_RES; r_res_st <= ST_GUARD;
                    end else begin
                        r_state <= i_stat.after_free ? S_F_FS : S_F_UPD;
                    end
                end
                S_F_FS:  r_state <= S_F_FNX;
                S_F_FNX: r_state <= S_F_UPD;
                S_F_UPD: r_state <= i_stat.before_free ? S_F_PW : S_F_W0;
                S_F_PW: begin
                    if (i_stat.after_free) begin
                        r_state <= S_F_PN;
                    end else begin
                        r_state <= S_RES; r_res_st <= ST_OK;
                    end
                end
                S_F_PN: begin
                    r_state <= S_RES; r_res_st <= ST_OK;
                end
                S_F_W0: r_state <= S_F_W1;
                S_F_W1: r_state <= S_F_W2;
                S_F_W2: begin
                    r_state <= S_RES; r_res_st <= ST_OK;
                end
                S_RES: begin
                    if (!i_stat.out_busy) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // issue the micro-operation of the current step
    always_comb begin
        o_cmd.st = r_res_st;
        case (r_state)
            S_INIT0:  o_cmd.op = C_INIT0;
            S_INIT1:  o_cmd.op = C_INIT1;
            S_IDLE:   o_cmd.op = i_s_tvalid ? C_LOAD : C_NOP;
            S_P_CHK:  o_cmd.op = C_P_RD;
            S_P_SZ:   o_cmd.op = C_P_SZ;
            S_P_NX:   o_cmd.op = C_P_NX;
            S_P_END:  o_cmd.op = C_P_END;
            S_P_BN:   o_cmd.op = C_P_BN;
            S_A_SIZE: o_cmd.op = C_A_SIZE;
            S_A_GRD:  o_cmd.op = C_A_GRD;
            S_A_RSZ:  o_cmd.op = C_A_RSZ;
            S_A_RNX:  o_cmd.op = C_A_RNX;
            S_A_LINK: o_cmd.op = C_A_LINK;
            S_F_CHK:  o_cmd.op = C_F_RD;
            S_F_SZ:   o_cmd.op = C_F_SZ;
            S_F_FN:   o_cmd.op = C_F_FN;
            S_F_END:  o_cmd.op = C_F_RD;
            S_F_GSZ:  o_cmd.op = C_F_GSZ;
            S_F_GRD:  o_cmd.op = C_F_FSRD;
            S_F_FS:   o_cmd.op = C_F_FS;
            S_F_FNX:  o_cmd.op = C_F_FNX;
            S_F_UPD:  o_cmd.op = i_stat.before_free ? C_F_PRD : C_NOP;
            S_F_PW:   o_cmd.op = C_F_PW;
            S_F_PN:   o_cmd.op = C_F_PN;
            S_F_W0:   o_cmd.op = C_F_W0;
            S_F_W1:   o_cmd.op = C_F_W1;
            S_F_W2:   o_cmd.op = C_F_W2;
            S_RES:    o_cmd.op = i_stat.out_busy ? C_NOP : C_RES;
            default:  o_cmd.op = C_NOP;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    `FLHA_ASSERT(a_accept_leaves_idle, i_s_tvalid && o_s_tready |=> !o_s_tready, "idle after accept")
    `FLHA_ASSERT(a_alloc_has_pick, r_state == S_A_SIZE |-> i_stat.pick_vld, "alloc without pick")
    `FLHA_ASSERT(a_free_at_target, r_state == S_F_W1 |-> i_stat.cur_eq_tgt, "free off target")
    `FLHA_ASSERT_NORST(a_init_after_reset, !i_rst_n |=> !o_s_tready, "ready during init")

endmodule

[src/free_list_heap_allocator_unit.sv]
`timescale 1ns / 1ps
// channel   | dir | handshake            | payload
// ----------+-----+----------------------+---------------------------------------
// request   | in  | i_s_tvalid/o_s_tready | tdata: req_size, free_addr; tuser: op
// result    | out | o_m_tvalid/i_m_tready | tdata: alloc_addr, status
// config    | in  | i_cfg_we             | i_cfg_wdata: fit_policy
//
// One request at a time; the arena is a 512 x 64 single-write, registered-read RAM.
// Allocate: walks the free list block by block, then writes size, guard, remainder and link (first fit stops early).
// Free: walks every block from the arena start up to the target, then merges with free neighbours.
// Synchronous reset, then S_INIT0 and S_INIT1 write the initial block header before ready.
// A finished result waits in the output register; a new request is taken meanwhile.
module free_list_heap_allocator_unit
    import flha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // req_size[12:0], free_addr[24:13], zero
    input  logic [0:0]  i_s_tuser,   // op[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // alloc_addr[11:0], status[14:12], zero
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata
);

    t_cmd        w_cmd;
    t_stat       w_stat;
    logic [11:0] w_alloc_addr;
    logic [2:0]  w_status;

    flha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    flha_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_op         (i_s_tuser[0]),
        .i_req_size   (i_s_tdata[12:0]),
        .i_free_addr  (i_s_tdata[24:13]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_alloc_addr (w_alloc_addr),
        .o_status     (w_status)
    );

    assign o_m_tdata = {1'b0, w_status, w_alloc_addr};

endmodule

[tb/sv/flha_checker.sv]
`timescale 1ns / 1ps
module flha_checker
    import flha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [11:0] addr;
        t_status     st;
    } t_alloc_result;

    bit [63:0]     heap_mem [NWORDS];
    bit [63:0]     head_off;
    logic [1:0]    policy;
    t_alloc_result result_q [$];

    function automatic bit [63:0] mem_rd(bit [63:0] off);
        return ((off >> 3) < NWORDS) ? heap_mem[off >> 3] : 64'd0;
    endfunction

    function automatic void mem_wr(bit [63:0] off, bit [63:0] v);
        if ((off >> 3) < NWORDS) heap_mem[off >> 3] = v;
    endfunction

    // walk the free list and choose a block; ARENA_BYTES when none fits
    function automatic bit [63:0] choose_block(bit [63:0] need);
        bit [63:0] cur, pick, best, n, sz;
        cur = head_off;
        pick = ARENA_BYTES;
        best = 0;
        n = 0;
        while (cur < ARENA_BYTES && n <= NWORDS) begin
            sz = mem_rd(cur);
            if (policy == POL_BEST) begin
                if (sz >= need && (pick == ARENA_BYTES || sz < best)) begin
                    pick = cur;
                    best = sz;
                end
            end else if (policy == POL_WORST) begin
                if (pick == ARENA_BYTES || sz >= best) begin
                    pick = cur;
                    best = sz;
                end
            end else if (sz >= need) begin
                return cur;
            end
            cur = mem_rd(cur + 8);
            n++;
        end
        if (policy == POL_WORST && pick != ARENA_BYTES && best < need) return ARENA_BYTES;
        return pick;
    endfunction

    // point the link that reaches blk at target
    function automatic void relink(bit [63:0] blk, bit [63:0] target);
        bit [63:0] cur, n, nx;
        cur = head_off;
        n = 0;
        if (cur == blk) begin
            head_off = target;
            return;
        end
        while (cur < ARENA_BYTES && n <= NWORDS) begin
            nx = mem_rd(cur + 8);
            if (nx == blk) begin
                mem_wr(cur + 8, target);
                return;
            end
            cur = nx;
            n++;
        end
    endfunction

    function automatic t_alloc_result predict_alloc(bit [63:0] req);
        t_alloc_result r;
        bit [63:0] need, blk, bsize, bnext, rest;
        r = '{addr: '0, st: ST_OK};
        if (req == 0) begin
            r.st = ST_ZERO;
            return r;
        end
        need = (req + OVERHEAD + 7) & ~64'd7;
        blk = choose_block(need);
        if (blk >= ARENA_BYTES) begin
            r.st = ST_NOFIT;
            return r;
        end
        bsize = mem_rd(blk);
        bnext = mem_rd(blk + 8);
        if (bsize - need >= MIN_REST) begin
            rest = blk + need;
            mem_wr(blk, need);
            mem_wr(blk + need - 8, '1);
            mem_wr(rest, bsize - need);
            mem_wr(rest + 8, bnext);
            relink(blk, rest);
        end else begin
            mem_wr(blk, bsize);
            mem_wr(blk + bsize - 8, '1);
            relink(blk, bnext);
        end
        r.addr = 12'(blk + 8);
        return r;
    endfunction

    function automatic t_status predict_free(bit [63:0] a);
        bit [63:0] target, cur, fcur, prevf, n, sz, fsize, fnext;
        bit have_prev, before_free, after_free;
        cur = HEADER_BYTES;
        fcur = head_off;
        prevf = 0;
        n = 0;
        fsize = 0;
        fnext = 0;
        have_prev = 0;
        before_free = 0;
        if (a < 8) return ST_NOBLK;
        target = a - 8;
        if (target >= ARENA_BYTES) return ST_NOBLK;
        // step block by block up to the target, tracking the free list
        while (cur < target && cur < ARENA_BYTES && n <= NWORDS) begin
            sz = mem_rd(cur);
            if (cur == fcur) begin
                prevf = fcur;
                have_prev = 1;
                fcur = mem_rd(fcur + 8);
                before_free = 1;
            end else begin
                before_free = 0;
            end
            if (sz == 0) break;
            cur += sz;
            n++;
        end
        if (cur != target) return ST_NOBLK;
        if (cur == fcur) return ST_FREED;
        sz = mem_rd(cur);
        if (sz < 8 || mem_rd(cur + sz - 8) != '1) return ST_GUARD;
        after_free = (fcur < ARENA_BYTES) && (cur + sz == fcur);
        if (after_free) begin
            fsize = mem_rd(fcur);
            fnext = mem_rd(fcur + 8);
        end
        // merge with free neighbors
        if (!have_prev) begin
            head_off = cur;
            mem_wr(cur, after_free ? sz + fsize : sz);
            mem_wr(cur + 8, after_free ? fnext : fcur);
        end else if (before_free && after_free) begin
            mem_wr(prevf, mem_rd(prevf) + sz + fsize);
            mem_wr(prevf + 8, fnext);
        end else if (before_free) begin
            mem_wr(prevf, mem_rd(prevf) + sz);
        end else if (after_free) begin
            mem_wr(prevf + 8, cur);
            mem_wr(cur, sz + fsize);
            mem_wr(cur + 8, fnext);
        end else begin
            mem_wr(prevf + 8, cur);
            mem_wr(cur + 8, fcur);
        end
        return ST_OK;
    endfunction

    assign o_pending = result_q.size();

    // compare each result transaction, then predict each request transaction
    always @(posedge i_clk) begin
        t_alloc_result got, want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            foreach (heap_mem[i]) heap_mem[i] = '0;
            mem_wr(HEADER_BYTES, ARENA_BYTES - HEADER_BYTES);
            mem_wr(HEADER_BYTES + 8, ARENA_BYTES);
            head_off = HEADER_BYTES;
            policy = POL_FIRST;
            result_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.addr = i_m_tdata[11:0];
                got.st = t_status'(i_m_tdata[14:12]);
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result addr=%0d status=%0d",
                             $time, got.addr, got.st);
                    errs++;
                end else begin
                    want = result_q.pop_front();
                    if (got.addr !== want.addr) begin
                        $display("%0t: alloc_addr expected %0d actual %0d",
                                 $time, want.addr, got.addr);
                        errs++;
                    end
                    if (got.st !== want.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, got.st);
                        errs++;
                    end
                end
            end
            if (i_cfg_we) policy = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == OP_ALLOC) begin
                    result_q.push_back(predict_alloc(64'(i_s_tdata[12:0])));
                end else begin
                    want = '{addr: '0, st: predict_free(64'(i_s_tdata[24:13]))};
                    result_q.push_back(want);
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
    import flha_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic [0:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [15:0] o_m_tdata;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          sent_cnt = 0;
    int          recv_cnt = 0;
    bit          req_taken = 0;
    bit          res_taken = 0;
    logic [15:0] res_word;
    bit          no_idle = 0;
    logic [11:0] live_addrs [$];
    logic [11:0] freed_addrs [$];

    always #1 i_clk = ~i_clk;

    free_list_heap_allocator_unit u_top (.*);

    flha_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // record handshakes at the edge, read back at the falling edge
    always @(posedge i_clk) begin
        req_taken <= i_s_tvalid && o_s_tready;
        res_taken <= o_m_tvalid && i_m_tready;
        if (o_m_tvalid && i_m_tready) res_word <= o_m_tdata;
    end

    task automatic send_req(logic op, logic [12:0] size, logic [11:0] addr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_s_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= op;
        i_s_tdata <= {7'd0, addr, size};
        do @(negedge i_clk); while (!req_taken);
        sent_cnt++;
    endtask

    task automatic send_random;
        int pick, k;
        logic [11:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 50 || (pick < 85 && live_addrs.size() == 0)) begin
            // mostly small sizes, a few large, zero now and then
            k = $urandom_range(0, 99);
            if (k < 3) send_req(OP_ALLOC, 0, 12'($urandom));
            else if (k < 10) send_req(OP_ALLOC, 13'($urandom_range(0, 4096)), 12'($urandom));
            else send_req(OP_ALLOC, 13'($urandom_range(1, 160)), 12'($urandom));
        end else if (pick < 85) begin
            k = $urandom_range(0, live_addrs.size() - 1);
            a = live_addrs[k];
            live_addrs.delete(k);
            freed_addrs.push_back(a);
            if (freed_addrs.size() > 16) void'(freed_addrs.pop_front());
            send_req(OP_FREE, 13'($urandom), a);
        end else if (pick < 92 && freed_addrs.size() > 0) begin
            send_req(OP_FREE, 13'($urandom),
                     freed_addrs[$urandom_range(0, freed_addrs.size() - 1)]);
        end else begin
            send_req(OP_FREE, 13'($urandom), 12'($urandom));
        end
    endtask

    // drop the request valid and let every result drain
    task automatic wait_idle;
        i_s_tvalid <= 0;
        while (recv_cnt != sent_cnt || pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_policy(logic [1:0] p);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= p;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // result side: random stall per transaction, keep returned offsets
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                i_m_tready <= 0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1;
            do @(negedge i_clk); while (!res_taken);
            recv_cnt++;
            if (res_word[14:12] == ST_OK && res_word[11:0] != 0)
                live_addrs.push_back(res_word[11:0]);
        end
    end

    initial begin
        logic [1:0] phases [7] = '{POL_FIRST, POL_BEST, POL_WORST, 2'd3,
                                   POL_BEST, POL_FIRST, POL_WORST};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        write_policy(POL_FIRST);

        // directed: zero size, no fit, whole-arena block, bad offsets, merges
        send_req(OP_ALLOC, 0, 12'hfff);
        send_req(OP_ALLOC, 4096, 0);
        send_req(OP_ALLOC, 4056, 0);
        send_req(OP_ALLOC, 1, 0);
        send_req(OP_FREE, 13'h1fff, 32);
        send_req(OP_FREE, 0, 32);
        send_req(OP_FREE, 0, 0);
        send_req(OP_FREE, 0, 7);
        send_req(OP_FREE, 0, 4095);
        send_req(OP_FREE, 0, 33);
        send_req(OP_ALLOC, 8, 0);
        send_req(OP_ALLOC, 8, 0);
        send_req(OP_ALLOC, 8, 0);
        send_req(OP_FREE, 0, 56);
        send_req(OP_FREE, 0, 32);
        send_req(OP_FREE, 0, 80);
        send_req(OP_FREE, 0, 80);
        send_req(OP_ALLOC, 4057, 0);
        send_req(OP_ALLOC, 4056, 0);
        send_req(OP_FREE, 0, 32);
        wait_idle();
        live_addrs.delete();
        freed_addrs.delete();

        // random phases across fit policies, with idle-free stretches
        foreach (phases[p]) begin
            write_policy(phases[p]);
            for (int i = 0; i < 220; i++) begin
                if (i % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
                send_random();
            end
            no_idle = 0;
            wait_idle();
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/flha_pkg.sv
src/flha_ram.sv
src/flha_dp.sv
src/flha_ctrl.sv
src/free_list_heap_allocator_unit.sv
tb/sv/flha_checker.sv
tb/sv/tb.sv
